>>> src/tun_pkg.sv
`timescale 1ns / 1ps
package tun_pkg;

  localparam int CW    = 33;
  localparam int PW    = 2 * CW;
  localparam int NW    = PW + 1;
  localparam int MW    = PW;
  localparam int HW    = MW / 2;
  localparam int SW    = 2 * MW;
  localparam int RW    = 168;
  localparam int QW    = 31;
  localparam int NCELL = QW;
  localparam int OW    = 32;

  typedef struct packed {
    logic                   vld;
    logic                   dgn;
    logic [SW-1:0]          len;
    logic [2:0][SW-1:0]     sq;
    logic [2:0]             neg;
  } tun_front_t;

  typedef struct packed {
    logic [RW-1:0] rem;
    logic [RW-1:0] acc;
    logic [SW-1:0] len;
    logic [QW-1:0] quo;
    logic          neg;
  } tun_cell_t;

endpackage

>>> src/tun_front.sv
`timescale 1ns / 1ps
module tun_front
  import tun_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              vld_i,
  input  logic [8:0][31:0]  vtx_i,
  output tun_front_t        res_o
);

  logic signed [CW-1:0] u_r [3];
  logic signed [CW-1:0] v_r [3];
  logic signed [PW-1:0] pa_r [3];
  logic signed [PW-1:0] pb_r [3];
  logic [MW-1:0]        m_r [3];
  logic [2:0]           neg3_r, neg4_r, neg5_r, neg6_r;
  logic [PW-1:0]        hh_r [3];
  logic [PW-1:0]        hl_r [3];
  logic [PW-1:0]        ll_r [3];
  logic [SW-1:0]        sq5_r [3];
  logic [SW-1:0]        sq6_r [3];
  logic [SW-1:0]        len_r;
  logic                 dg4_r, dg5_r, dg6_r;
  logic [5:0]           vld_r;
  logic [NW-1:0]        n_nxt [3];
  logic [MW-1:0]        m_nxt [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      n_nxt[i] = {pa_r[i][PW-1], pa_r[i]} - {pb_r[i][PW-1], pb_r[i]};
      m_nxt[i] = n_nxt[i][NW-1] ? MW'(NW'(0) - n_nxt[i]) : n_nxt[i][MW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[4:0], vld_i};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        u_r[i] <= CW'($signed(vtx_i[i]))     - CW'($signed(vtx_i[6 + i]));
        v_r[i] <= CW'($signed(vtx_i[3 + i])) - CW'($signed(vtx_i[6 + i]));
      end
      pa_r[0] <= u_r[1] * v_r[2];
      pb_r[0] <= u_r[2] * v_r[1];
      pa_r[1] <= u_r[2] * v_r[0];
      pb_r[1] <= u_r[0] * v_r[2];
      pa_r[2] <= u_r[0] * v_r[1];
      pb_r[2] <= u_r[1] * v_r[0];
      for (int i = 0; i < 3; i++) begin
        m_r[i]    <= m_nxt[i];
        neg3_r[i] <= n_nxt[i][NW-1];
        hh_r[i]   <= m_r[i][MW-1:HW] * m_r[i][MW-1:HW];
        hl_r[i]   <= m_r[i][MW-1:HW] * m_r[i][HW-1:0];
        ll_r[i]   <= m_r[i][HW-1:0] * m_r[i][HW-1:0];
        sq5_r[i]  <= {hh_r[i], {MW{1'b0}}} + SW'({hl_r[i], {(HW + 1){1'b0}}})
                     + SW'(ll_r[i]);
        sq6_r[i]  <= sq5_r[i];
      end
      neg4_r <= neg3_r;
      neg5_r <= neg4_r;
      neg6_r <= neg5_r;
      dg4_r  <= (m_r[0] == '0) && (m_r[1] == '0) && (m_r[2] == '0);
      dg5_r  <= dg4_r;
      dg6_r  <= dg5_r;
      len_r  <= sq5_r[0] + sq5_r[1] + sq5_r[2];
    end
  end

  always_comb begin
    res_o.vld = vld_r[5];
    res_o.dgn = dg6_r;
    res_o.len = len_r;
    res_o.neg = neg6_r;
    for (int i = 0; i < 3; i++) begin
      res_o.sq[i] = sq6_r[i];
    end
  end

endmodule

>>> src/tun_cell.sv
`timescale 1ns / 1ps
module tun_cell
  import tun_pkg::*;
(
  input  logic       clk,
  input  logic       en,
  input  tun_cell_t  d_i,
  output tun_cell_t  q_o
);

  logic [RW+1:0] trial;
  logic [RW+1:0] diff;
  logic          take;
  logic [RW-1:0] rem_sel;
  logic [RW-1:0] acc_sel;
  tun_cell_t     cell_r;

  always_comb begin
    trial   = {1'b0, d_i.acc, 1'b0} + (RW + 2)'(d_i.len);
    diff    = {2'b00, d_i.rem} - trial;
    take    = !diff[RW+1];
    rem_sel = take ? diff[RW-1:0] : d_i.rem;
    acc_sel = take ? d_i.acc + RW'(d_i.len) : d_i.acc;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cell_r.rem <= {rem_sel[RW-3:0], 2'b00};
      cell_r.acc <= {acc_sel[RW-2:0], 1'b0};
      cell_r.len <= d_i.len;
      cell_r.quo <= {d_i.quo[QW-2:0], take};
      cell_r.neg <= d_i.neg;
    end
  end

  assign q_o = cell_r;

endmodule

>>> src/triangle_unit_normal.sv
`timescale 1ns / 1ps
// Unit normal of a triangle: takes vertices a, b, c in signed Q16.16, forms
// (a-c) x (b-c) exactly and returns each component over the vector length in
// signed Q1.30, truncated toward zero. A zero cross product gives zeros and
// raises out_degenerate. One triangle is taken per cycle while in_stall is low;
// a result passes through 6 front stages for edges, cross product, squares
// and length, 31 restoring cells per component that each resolve one quotient
// bit, and one output register. A stall on the result side while out_valid is
// high freezes the whole pipeline and shows on in_stall.
module triangle_unit_normal
  import tun_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_vertex_a_x,
  input  logic [31:0] in_vertex_a_y,
  input  logic [31:0] in_vertex_a_z,
  input  logic [31:0] in_vertex_b_x,
  input  logic [31:0] in_vertex_b_y,
  input  logic [31:0] in_vertex_b_z,
  input  logic [31:0] in_vertex_c_x,
  input  logic [31:0] in_vertex_c_y,
  input  logic [31:0] in_vertex_c_z,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_normal_x,
  output logic [31:0] out_normal_y,
  output logic [31:0] out_normal_z,
  output logic        out_degenerate
);

  logic             en;
  logic [8:0][31:0] vtx;
  tun_front_t       front;
  tun_cell_t        lane [3][NCELL+1];
  logic [NCELL-1:0] vld_r;
  logic [NCELL-1:0] dgn_r;
  logic             out_valid_r;
  logic             dgn_out_r;
  logic [OW-1:0]    nrm_r [3];
  logic [OW-1:0]    nrm_nxt [3];

  assign en       = !(out_valid_r && out_stall);
  assign in_stall = !en;
  assign vtx      = {in_vertex_c_z, in_vertex_c_y, in_vertex_c_x,
                     in_vertex_b_z, in_vertex_b_y, in_vertex_b_x,
                     in_vertex_a_z, in_vertex_a_y, in_vertex_a_x};

  tun_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .vld_i (in_valid),
    .vtx_i (vtx),
    .res_o (front)
  );

  for (genvar l = 0; l < 3; l++) begin : g_lane
    always_comb begin
      lane[l][0].rem = RW'(front.sq[l]);
      lane[l][0].acc = '0;
      lane[l][0].len = front.len;
      lane[l][0].quo = '0;
      lane[l][0].neg = front.neg[l];
    end
    for (genvar c = 0; c < NCELL; c++) begin : g_cell
      tun_cell u_cell (
        .clk (clk),
        .en  (en),
        .d_i (lane[l][c]),
        .q_o (lane[l][c+1])
      );
    end
    always_comb begin
      if (dgn_r[NCELL-1]) begin
        nrm_nxt[l] = '0;
      end else if (lane[l][NCELL].neg) begin
        nrm_nxt[l] = OW'(0) - OW'(lane[l][NCELL].quo);
      end else begin
        nrm_nxt[l] = OW'(lane[l][NCELL].quo);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r       <= {vld_r[NCELL-2:0], front.vld};
      out_valid_r <= vld_r[NCELL-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dgn_r     <= {dgn_r[NCELL-2:0], front.dgn};
      dgn_out_r <= dgn_r[NCELL-1];
      for (int i = 0; i < 3; i++) begin
        nrm_r[i] <= nrm_nxt[i];
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_degenerate = dgn_out_r;
  assign out_normal_x   = nrm_r[0];
  assign out_normal_y   = nrm_r[1];
  assign out_normal_z   = nrm_r[2];

endmodule

>>> src/tun_checker.sv
`timescale 1ns / 1ps
module tun_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_normal_x,
  input logic [31:0] out_normal_y,
  input logic [31:0] out_normal_z,
  input logic        out_degenerate
);

  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_degenerate |->
      out_normal_x == '0 && out_normal_y == '0 && out_normal_z == '0)
    else $error("degenerate result with nonzero normal");

  a_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_degenerate |->
      out_normal_x != '0 || out_normal_y != '0 || out_normal_z != '0)
    else $error("regular result with zero normal");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |->
      $signed(out_normal_x) <= 32'sd1073741824 &&
      $signed(out_normal_x) >= -32'sd1073741824)
    else $error("normal x out of range");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output stall");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_normal_x) &&
      $stable(out_degenerate))
    else $error("stalled result changed");

endmodule

bind triangle_unit_normal tun_checker u_tun_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_normal_x   (out_normal_x),
  .out_normal_y   (out_normal_y),
  .out_normal_z   (out_normal_z),
  .out_degenerate (out_degenerate)
);
